// File: rtl/core/ole_pkg.sv
// Shared op codes, status codes and the command control word for the ordered list engine.
package ole_pkg;

  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_PREPEND    = 3'd1;
  localparam logic [2:0] OP_INSERT_AT  = 3'd2;
  localparam logic [2:0] OP_DROP_BACK  = 3'd3;
  localparam logic [2:0] OP_DROP_FRONT = 3'd4;
  localparam logic [2:0] OP_REMOVE_AT  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } ole_status_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } ole_kind_t;

  typedef struct packed {
    ole_kind_t   kind;
    ole_status_t status;
  } ole_ctl_t;

endpackage

// File: rtl/core/ordered_list_engine.sv
// Top level of the ordered list engine: front end, command queue and cell array.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+------------------------------
//  request | in_op, in_value, in_position                 | taken when in_push && !in_full
//  result  | out_item_count, out_front_value, out_status  | taken when out_pop && !out_empty
//
// One request per cycle sustained while in_full stays low; all cells shift at once.
// A request waits in the command queue; its result is then registered after the cell row.
// Reset (rst_n low, synchronous) empties list, command queue, result register; cells keep data.
// in_full rises only when the two-entry command queue is full, i.e. results are not being popped.
module ordered_list_engine #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [2:0]                    in_op,
  input  logic [DATA_WIDTH-1:0]         in_value,
  input  logic [$clog2(DEPTH+1)-1:0]    in_position,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [$clog2(DEPTH+1)-1:0]    out_item_count,
  output logic [DATA_WIDTH-1:0]         out_front_value,
  output logic [1:0]                    out_status
);
  import ole_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CTL_W = $bits(ole_ctl_t);
  localparam int Q_W   = CTL_W + CNT_W + DATA_WIDTH + CNT_W;

  logic                  accept;
  logic                  q_full;
  logic                  q_push;
  logic                  q_empty;
  logic                  q_pop;
  logic [Q_W-1:0]        q_din;
  logic [Q_W-1:0]        q_dout;
  ole_ctl_t              fe_ctl;
  logic [CNT_W-1:0]      fe_pos;
  logic [CNT_W-1:0]      fe_count;
  ole_ctl_t              be_ctl;
  logic [CNT_W-1:0]      be_pos;
  logic [DATA_WIDTH-1:0] be_value;
  logic [CNT_W-1:0]      be_count;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  ole_front #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (accept),
    .req_op       (in_op),
    .req_position (in_position),
    .cmd_push     (q_push),
    .cmd_ctl      (fe_ctl),
    .cmd_pos      (fe_pos),
    .cmd_count    (fe_count)
  );

  assign q_din = {fe_ctl, fe_pos, in_value, fe_count};

  ole_fifo #(
    .W (Q_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {be_ctl, be_pos, be_value, be_count} = q_dout;

  ole_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (q_empty),
    .cmd_pop         (q_pop),
    .cmd_ctl         (be_ctl),
    .cmd_pos         (be_pos),
    .cmd_value       (be_value),
    .cmd_count       (be_count),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_item_count  (out_item_count),
    .out_front_value (out_front_value),
    .out_status      (out_status)
  );

endmodule

// File: rtl/core/ole_front.sv
// Front end: takes requests, checks them against the running length, issues cell commands.
module ole_front #(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid,
  input  logic [2:0]                   req_op,
  input  logic [CNT_W-1:0]             req_position,
  output logic                         cmd_push,
  output ole_pkg::ole_ctl_t            cmd_ctl,
  output logic [CNT_W-1:0]             cmd_pos,
  output logic [CNT_W-1:0]             cmd_count
);
  import ole_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             is_full;
  logic             is_empty;

  assign is_full  = (count_r == DEPTH_C);
  assign is_empty = (count_r == '0);
  assign cmd_push = req_valid;

  always_comb begin
    cmd_ctl.kind   = CMD_NONE;
    cmd_ctl.status = ST_OK;
    cmd_pos        = '0;
    count_nxt      = count_r;
    case (req_op)
      OP_APPEND: begin
        if (is_full) begin
          cmd_ctl.status = ST_FULL;
        end else begin
          cmd_ctl.kind = CMD_INSERT;
          cmd_pos      = count_r;
          count_nxt    = count_r + ONE_C;
        end
      end
      OP_PREPEND: begin
        if (is_full) begin
          cmd_ctl.status = ST_FULL;
        end else begin
          cmd_ctl.kind = CMD_INSERT;
          count_nxt    = count_r + ONE_C;
        end
      end
      OP_INSERT_AT: begin
        if (req_position > count_r) begin
          cmd_ctl.status = ST_BAD_INDEX;
        end else if (is_full) begin
          cmd_ctl.status = ST_FULL;
        end else begin
          cmd_ctl.kind = CMD_INSERT;
          cmd_pos      = req_position;
          count_nxt    = count_r + ONE_C;
        end
      end
      OP_DROP_BACK: begin
        if (is_empty) begin
          cmd_ctl.status = ST_EMPTY;
        end else begin
          // removing the last slot: nothing below it moves
          cmd_ctl.kind = CMD_REMOVE;
          cmd_pos      = count_r - ONE_C;
          count_nxt    = count_r - ONE_C;
        end
      end
      OP_DROP_FRONT: begin
        if (is_empty) begin
          cmd_ctl.status = ST_EMPTY;
        end else begin
          cmd_ctl.kind = CMD_REMOVE;
          count_nxt    = count_r - ONE_C;
        end
      end
      OP_REMOVE_AT: begin
        if (is_empty) begin
          cmd_ctl.status = ST_EMPTY;
        end else if (req_position >= count_r) begin
          cmd_ctl.status = ST_BAD_INDEX;
        end else begin
          cmd_ctl.kind = CMD_REMOVE;
          cmd_pos      = req_position;
          count_nxt    = count_r - ONE_C;
        end
      end
      default: begin
        cmd_ctl.kind = CMD_NONE;
      end
    endcase
  end

  assign cmd_count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (req_valid) begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/ole_fifo.sv
// Two-entry command queue between the front end and the cell array.
module ole_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   fill_r;
  logic         do_push;
  logic         do_pop;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// File: rtl/core/ole_back.sv
// Back end: row of list cells that shift together, plus the result register.
module ole_back #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  input  ole_pkg::ole_ctl_t     cmd_ctl,
  input  logic [CNT_W-1:0]      cmd_pos,
  input  logic [DATA_WIDTH-1:0] cmd_value,
  input  logic [CNT_W-1:0]      cmd_count,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [CNT_W-1:0]      out_item_count,
  output logic [DATA_WIDTH-1:0] out_front_value,
  output logic [1:0]            out_status
);
  import ole_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] cells_r [DEPTH];
  logic                  fire;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [DATA_WIDTH-1:0] cell0_nxt;
  logic [CNT_W-1:0]      out_count_r;
  logic [DATA_WIDTH-1:0] out_front_r;
  ole_status_t           out_status_r;

  // result register frees up in the same cycle it is popped
  assign fire          = !cmd_empty && (!out_valid_r || out_pop);
  assign cmd_pop       = fire;
  assign out_valid_nxt = fire || (out_valid_r && !out_pop);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    always_ff @(posedge clk) begin
      if (fire) begin
        case (cmd_ctl.kind)
          CMD_INSERT: begin
            if (IDX == cmd_pos) begin
              cells_r[i] <= cmd_value;
            end else if (IDX > cmd_pos) begin
              if (i > 0) begin
                cells_r[i] <= cells_r[(i > 0) ? i - 1 : 0];
              end
            end
          end
          CMD_REMOVE: begin
            if (IDX >= cmd_pos) begin
              if (i < DEPTH - 1) begin
                cells_r[i] <= cells_r[(i < DEPTH - 1) ? i + 1 : i];
              end
            end
          end
          default: begin
            cells_r[i] <= cells_r[i];
          end
        endcase
      end
    end
  end

  always_comb begin
    cell0_nxt = cells_r[0];
    case (cmd_ctl.kind)
      CMD_INSERT: begin
        if (cmd_pos == '0) begin
          cell0_nxt = cmd_value;
        end
      end
      CMD_REMOVE: begin
        if (cmd_pos == '0) begin
          cell0_nxt = cells_r[(DEPTH > 1) ? 1 : 0];
        end
      end
      default: begin
        cell0_nxt = cells_r[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_count_r  <= cmd_count;
      out_status_r <= cmd_ctl.status;
      out_front_r  <= (cmd_count == '0) ? '0 : cell0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_item_count  = out_count_r;
  assign out_front_value = out_front_r;
  assign out_status      = out_status_r;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("command taken but no result held");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= DEPTH_C))
    else $error("result length beyond capacity");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == DEPTH_C))
    else $error("full status with spare room");

  a_empty_front_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r == '0) |-> (out_front_r == '0))
    else $error("empty list shows a front value");

endmodule

// File: tb/tb_ordered_list_engine.sv
// Self-checking testbench for the ordered list engine: directed corners, then biased random traffic.
module tb_ordered_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ole_pkg::*;

  localparam int DEPTH           = 64;
  localparam int DATA_WIDTH      = 32;
  localparam int POS_W           = $clog2(DEPTH + 1);
  localparam int RANDOM_REQUESTS = 1000;
  localparam int MAX_REPORTS     = 10;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 10;

  // op codes the block leaves unused
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [POS_W-1:0]      count;
    logic [DATA_WIDTH-1:0] front;
    ole_status_t           status;
  } list_result_t;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} fill_bias_t;

  class list_scoreboard;
    logic [DATA_WIDTH-1:0] entries[$];
    list_result_t          expected[$];
    int                    mismatches;
    int                    requests;
    int                    results;
    int                    status_hits[4];
    int                    peak_length;

    function int length();
      return entries.size();
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // Apply one accepted request to the list copy and queue the result it must produce.
    function void note_request(logic [2:0] op, logic [DATA_WIDTH-1:0] value,
                               logic [POS_W-1:0] position);
      ole_status_t  st;
      list_result_t r;
      int           n;
      n  = entries.size();
      st = ST_OK;
      case (op)
        OP_APPEND: begin
          if (n >= DEPTH) st = ST_FULL;
          else entries.push_back(value);
        end
        OP_PREPEND: begin
          if (n >= DEPTH) st = ST_FULL;
          else entries.push_front(value);
        end
        OP_INSERT_AT: begin
          // index is checked before fullness
          if (int'(position) > n) st = ST_BAD_INDEX;
          else if (n >= DEPTH) st = ST_FULL;
          else entries.insert(int'(position), value);
        end
        OP_DROP_BACK: begin
          if (n == 0) st = ST_EMPTY;
          else void'(entries.pop_back());
        end
        OP_DROP_FRONT: begin
          if (n == 0) st = ST_EMPTY;
          else void'(entries.pop_front());
        end
        OP_REMOVE_AT: begin
          if (n == 0) st = ST_EMPTY;
          else if (int'(position) >= n) st = ST_BAD_INDEX;
          else entries.delete(int'(position));
        end
        default: ;
      endcase
      r.count  = POS_W'(entries.size());
      r.front  = (entries.size() > 0) ? entries[0] : '0;
      r.status = st;
      expected.push_back(r);
      requests++;
      status_hits[st]++;
      if (entries.size() > peak_length) peak_length = entries.size();
    endfunction

    function void check_result(logic [POS_W-1:0] cnt, logic [DATA_WIDTH-1:0] front,
                               logic [1:0] st);
      list_result_t e;
      results++;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: count=%0d front=%h status=%0d",
                   $realtime, cnt, front, st);
        return;
      end
      e = expected.pop_front();
      if (cnt !== e.count || front !== e.front || st !== e.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch: count exp %0d got %0d, front exp %h got %h, status exp %0d got %0d",
                   $realtime, e.count, cnt, e.front, front, e.status, st);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [2:0]            in_op = OP_APPEND;
  logic [DATA_WIDTH-1:0] in_value = '0;
  logic [POS_W-1:0]      in_position = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [POS_W-1:0]      out_item_count;
  logic [DATA_WIDTH-1:0] out_front_value;
  logic [1:0]            out_status;

  list_scoreboard sb = new();

  int idle_cycles = 0;
  int pop_mode = 0;
  int mode_left = 0;

  ordered_list_engine #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_item_count  (out_item_count),
    .out_front_value (out_front_value),
    .out_status      (out_status)
  );

  always #5 clk = ~clk;

  // Receiver: always-ready, coin-flip and long-stall stretches picked at random.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      pop_mode  = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (pop_mode)
      0:       out_pop <= 1'b1;
      1:       out_pop <= ($urandom_range(0, 1) == 1);
      default: out_pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result(out_item_count, out_front_value, out_status);
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] op, logic [DATA_WIDTH-1:0] value,
                              logic [POS_W-1:0] position);
    @(negedge clk);
    in_push     <= 1'b1;
    in_op       <= op;
    in_value    <= value;
    in_position <= position;
    do @(posedge clk); while (in_full);
    sb.note_request(op, value, position);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    in_push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_request(fill_bias_t bias);
    logic [2:0]            op;
    logic [DATA_WIDTH-1:0] value;
    logic [POS_W-1:0]      position;
    int                    n;
    int                    grow_pct;
    n = sb.length();
    case (bias)
      BIAS_FILL:  grow_pct = 90;
      BIAS_DRAIN: grow_pct = 10;
      default:    grow_pct = 50;
    endcase
    if ($urandom_range(0, 99) < 2) begin
      op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       op = OP_APPEND;
        1:       op = OP_PREPEND;
        default: op = OP_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       op = OP_DROP_BACK;
        1:       op = OP_DROP_FRONT;
        default: op = OP_REMOVE_AT;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom;
    endcase
    position = POS_W'($urandom_range(0, DEPTH));
    if (op == OP_INSERT_AT && $urandom_range(0, 99) < 85)
      position = POS_W'($urandom_range(0, n));
    else if (op == OP_REMOVE_AT && n > 0 && $urandom_range(0, 99) < 85)
      position = POS_W'($urandom_range(0, n - 1));
    send_request(op, value, position);
  endtask

  initial begin
    fill_bias_t bias;
    int         sent;
    int         burst_left;
    int         segment;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners: empty-list removals, bad indices, value extremes, spare ops
    send_request(OP_DROP_BACK,  32'h0000_0000, 7'd0);
    send_request(OP_DROP_FRONT, 32'hFFFF_FFFF, 7'd64);
    send_request(OP_REMOVE_AT,  32'h0000_0000, 7'd0);
    send_request(OP_INSERT_AT,  32'h1234_5678, 7'd1);
    send_request(OP_INSERT_AT,  32'h0000_0000, 7'd0);
    send_request(OP_APPEND,     32'hFFFF_FFFF, 7'd0);
    send_request(OP_PREPEND,    32'h8000_0001, 7'd64);
    send_request(OP_INSERT_AT,  32'h5A5A_A5A5, 7'd3);
    send_request(OP_INSERT_AT,  32'hA5A5_5A5A, 7'd1);
    send_request(OP_REMOVE_AT,  32'h0000_0000, 7'd5);
    send_request(OP_REMOVE_AT,  32'h0000_0000, 7'd2);
    send_request(OP_REMOVE_AT,  32'hFFFF_FFFF, 7'd64);
    send_request(OP_INSERT_AT,  32'hFFFF_FFFF, 7'd64);
    send_request(OP_SPARE_A,    32'hFFFF_FFFF, 7'd64);
    send_request(OP_SPARE_B,    32'h0000_0000, 7'd0);
    send_request(OP_REMOVE_AT,  32'h0000_0000, 7'd0);
    send_request(OP_DROP_FRONT, 32'h0000_0000, 7'd0);
    send_request(OP_DROP_BACK,  32'h0000_0000, 7'd0);
    send_request(OP_DROP_BACK,  32'h0000_0000, 7'd0);
    wait_drained();

    // random phases, each biased towards filling, draining or neither
    sent       = 0;
    burst_left = $urandom_range(1, 30);
    while (sent < RANDOM_REQUESTS) begin
      bias    = fill_bias_t'($urandom_range(0, 2));
      segment = $urandom_range(40, 150);
      repeat (segment) begin
        random_request(bias);
        sent++;
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
          burst_left = $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
        if (sent % 300 == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests over fill, drain and mixed phases (peak length %0d); %0d results checked",
             sb.requests, sb.peak_length, sb.results);
    $display("Status seen: ok %0d, bad index %0d, empty %0d, full %0d; mismatches %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_BAD_INDEX], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_FULL], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ole_pkg.sv
rtl/core/ole_front.sv
rtl/core/ole_fifo.sv
rtl/core/ole_back.sv
rtl/core/ordered_list_engine.sv
tb/tb_ordered_list_engine.sv
